// ===== rtl/ewkq_pkg.sv =====
`default_nettype none

package ewkq_pkg;

	// Store and field geometry.
	localparam int SAMPLE_DEPTH = 4096;
	localparam int ADDR_W       = 12;
	localparam int COUNT_W      = 13;
	localparam int SAMPLE_W     = 8;
	localparam int FRAC_BITS    = 4;
	localparam int THR_W        = SAMPLE_W + FRAC_BITS;
	localparam int WIN_W        = 5;
	localparam int HALF_W       = WIN_W - 1;
	localparam int MAX_WINDOW   = 16;
	localparam int WIN_RESET    = 4;
	localparam int FUNC_W       = 2;
	localparam int CFG_IDX_W    = 2;

	// Command codes carried on func.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND  = 2'd0,
		FUNC_QUERY   = 2'd1,
		FUNC_RESTART = 2'd2
	} func_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN = 2'd0,
		REG_UPPER_THR  = 2'd1,
		REG_LOWER_THR  = 2'd2
	} reg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic append;
		logic restart;
		logic query;
		logic rd_en;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bounds_ok;
		logic last_rd;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/ewkq_ctrl.sv =====
`default_nettype none

module ewkq_ctrl
	import ewkq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FUNC_W-1:0] func,
	input  wire status_t           status,
	output cmd_t                   cmd,
	output logic                   busy
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FUNC_APPEND:  cmd.append  = 1'b1;
						FUNC_RESTART: cmd.restart = 1'b1;
						FUNC_QUERY: begin
							cmd.query = 1'b1;
							// A window outside the stored samples needs no reads.
							state_d = status.bounds_ok ? ST_ISSUE : ST_FINISH;
						end
						default: ;
					endcase
				end
			end
			ST_ISSUE: begin
				cmd.rd_en = 1'b1;
				if (status.last_rd) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ewkq_dp.sv =====
`default_nettype none

module ewkq_dp
	import ewkq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [THR_W-1:0]     cfg_data,
	input  wire logic [SAMPLE_W-1:0]  sample,
	input  wire logic [ADDR_W-1:0]    query_index,
	output status_t                   status,
	output logic                      result_valid,
	output logic [ADDR_W-1:0]         echo_index,
	output logic                      keep,
	output logic                      key_bit
);

	logic [WIN_W-1:0]         window_len_q;
	logic signed [THR_W-1:0]  upper_q;
	logic signed [THR_W-1:0]  lower_q;
	logic [COUNT_W-1:0]       count_q;
	logic [SAMPLE_W-1:0]      mem [SAMPLE_DEPTH];
	logic [SAMPLE_W-1:0]      rd_data_s1;
	logic                     rd_vld_s1;
	logic [ADDR_W-1:0]        addr_q;
	logic [ADDR_W-1:0]        last_q;
	logic [ADDR_W-1:0]        echo_q;
	logic                     ok_q;
	logic                     q_q;
	logic                     first_q;
	logic                     result_valid_q;
	logic                     keep_q;
	logic                     key_q;

	logic [WIN_W-1:0]         win_sat;
	logic [WIN_W-1:0]         win_even;
	logic [HALF_W-1:0]        after;
	logic [HALF_W-1:0]        lead;
	logic                     full;
	logic signed [THR_W-1:0]  scaled;
	logic                     above;
	logic                     below;
	logic                     decided;
	logic                     ok_d;
	logic                     q_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WIN_W'(WIN_RESET);
			upper_q      <= '0;
			lower_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LEN: window_len_q <= cfg_data[WIN_W-1:0];
				REG_UPPER_THR:  upper_q      <= cfg_data;
				REG_LOWER_THR:  lower_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective window: saturated, rounded down to even, at least two.
	always_comb begin
		win_sat  = (window_len_q > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_len_q;
		win_even = {win_sat[WIN_W-1:1], 1'b0};
		if (win_even < WIN_W'(2)) begin
			win_even = WIN_W'(2);
		end
		after = win_even[WIN_W-1:1];
		lead  = after - HALF_W'(1);
	end

	// The window must lie wholly inside the stored samples.
	assign status.bounds_ok = (query_index >= ADDR_W'(lead)) &&
		(({2'b00, query_index} + (COUNT_W + 1)'(after)) < {1'b0, count_q});
	assign status.last_rd = (addr_q == last_q);

	assign full = (count_q == COUNT_W'(SAMPLE_DEPTH));

	// Sample count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.restart) begin
			count_q <= '0;
		end else if (cmd.append && !full) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	// Sample store: one write port for appends, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem[count_q[ADDR_W-1:0]] <= sample;
		end
		rd_data_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	// Read address walks the window from its first to its last sample.
	always_ff @(posedge clk) begin
		if (cmd.query) begin
			addr_q <= query_index - ADDR_W'(lead);
			last_q <= query_index + ADDR_W'(after);
			echo_q <= query_index;
		end else if (cmd.rd_en) begin
			addr_q <= addr_q + ADDR_W'(1);
		end
	end

	// Quantize the sample read out; the upper test wins when thresholds cross.
	always_comb begin
		scaled  = signed'({rd_data_s1, FRAC_BITS'(0)});
		above   = (scaled > upper_q);
		below   = (scaled < lower_q);
		decided = above || below;
	end

	// Agreement check: the first sample sets the bit, the rest must match it.
	always_comb begin
		ok_d = ok_q;
		q_d  = q_q;
		if (rd_vld_s1) begin
			if (first_q) begin
				ok_d = ok_q && decided;
				q_d  = above;
			end else begin
				ok_d = ok_q && decided && (above == q_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q    <= 1'b0;
			q_q     <= 1'b0;
			first_q <= 1'b0;
		end else if (cmd.query) begin
			ok_q    <= status.bounds_ok;
			q_q     <= 1'b0;
			first_q <= 1'b1;
		end else if (rd_vld_s1) begin
			ok_q    <= ok_d;
			q_q     <= q_d;
			first_q <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			keep_q <= ok_d;
			key_q  <= ok_d && q_d;
		end
	end

	assign result_valid = result_valid_q;
	assign echo_index   = echo_q;
	assign keep         = keep_q;
	assign key_bit      = key_q;

endmodule

`default_nettype wire

// ===== rtl/excursion_window_key_quantizer.sv =====
`default_nettype none

// Excursion-window key quantizer. A command is taken when start is high and busy
// is low. Appending a sample, restarting the sample set and an unused code
// leave the block idle and give no result. A query reads its window of W
// samples (W the effective window length, 2 to 16, four after reset) through
// the single registered read port of the sample store, one per cycle, keeping
// busy high until its result is registered; a window outside the stored samples
// needs no reads. The result appears on echo_index, keep and key_bit
// for exactly one cycle, marked by result_valid, and must be taken in that cycle:
// there is no way to hold it off. Configuration writes are always accepted
// (cfg_ready is tied high) and are meant to be made while the block is idle.

module excursion_window_key_quantizer
	import ewkq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic [ADDR_W-1:0]     query_index,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [THR_W-1:0]      cfg_data,
	output logic                       result_valid,
	output logic [ADDR_W-1:0]          echo_index,
	output logic                       keep,
	output logic                       key_bit
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// Sequencer.
	ewkq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Sample store, window check and result register.
	ewkq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.query_index  (query_index),
		.status       (status),
		.result_valid (result_valid),
		.echo_index   (echo_index),
		.keep         (keep),
		.key_bit      (key_bit)
	);

	// A result is only ever presented once the block has gone idle.
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

	// Result strobes never come on consecutive cycles.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe lasted more than one cycle");

	// A rejected index never carries a key bit.
	a_key_needs_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !keep) |-> !key_bit)
		else $error("key bit set on a rejected index");

	// An accepted query always occupies the block in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_QUERY)) |=> busy)
		else $error("query accepted but block not busy");

endmodule

`default_nettype wire
